@@ hdl/ufss_pkg.sv @@
// ufss_pkg: shared widths, node record layout, controller states and the
// command/status structs between ufss_ctrl and ufss_dp.
// No dependencies.
`default_nettype none

package ufss_pkg;

  localparam int ID_W       = 12;
  localparam int NODES      = 1 << ID_W;
  localparam int SIZE_W     = 13;
  localparam int TAG_W      = 8;
  localparam int IN_DATA_W  = 2 * ID_W;
  localparam int OUT_DATA_W = ((SIZE_W + 7) / 8) * 8;

  typedef logic [ID_W-1:0]   node_id_t;
  typedef logic [SIZE_W-1:0] set_size_t;
  typedef logic [TAG_W-1:0]  tag_t;

  // tag == current epoch marks a node seen since the last clear
  typedef struct packed {
    tag_t      tag;
    node_id_t  parent;
    set_size_t size;
  } node_rec_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SEEN_RD,
    ST_SEEN_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_MERGE,
    ST_MERGE_WIN,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_NODE,
    RD_CUR
  } rd_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SWEEP,
    WR_NEW,
    WR_COMP,
    WR_LOSER,
    WR_WINNER
  } wr_op_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_A,
    CUR_B,
    CUR_PARENT
  } cur_op_t;

  typedef struct packed {
    logic    capture;
    logic    epoch_step;
    logic    side;
    rd_op_t  rd_op;
    wr_op_t  wr_op;
    cur_op_t cur_op;
    logic    root_load;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic tag_match;
    logic at_root;
    logic cur_is_root;
    logic roots_equal;
    logic epoch_last;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/ufss_dp.sv @@
// ufss_dp: node record memory, walk/root/size registers, epoch and sweep
// counters, output register. Depends on ufss_pkg.
`default_nettype none

module ufss_dp (
  input  wire                            clk,
  input  wire                            rst,
  input  ufss_pkg::dp_cmd_t              cmd,
  output ufss_pkg::dp_status_t           status,
  input  wire [ufss_pkg::IN_DATA_W-1:0]  in_data,
  input  wire                            m_tready,
  output logic                           m_tvalid,
  output logic [ufss_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ufss_pkg::*;

  node_rec_t mem [NODES];
  node_rec_t rdata;
  node_rec_t wr_data;
  node_id_t  wr_addr;
  logic      wr_en;
  node_id_t  rd_addr;

  node_id_t  node_a;
  node_id_t  node_b;
  node_id_t  cur;
  node_id_t  root_a;
  node_id_t  root_b;
  set_size_t size_a;
  set_size_t size_b;
  tag_t      epoch;
  node_id_t  sweep_cnt;

  node_id_t  node_sel;
  node_id_t  root_sel;
  node_id_t  winner;
  node_id_t  loser;
  set_size_t loser_size;
  set_size_t sum;
  set_size_t result;

  assign node_sel   = cmd.side ? node_b : node_a;
  assign root_sel   = cmd.side ? root_b : root_a;
  assign winner     = (root_a < root_b) ? root_a : root_b;
  assign loser      = (root_a < root_b) ? root_b : root_a;
  assign loser_size = (root_a < root_b) ? size_b : size_a;
  assign sum        = size_a + size_b;
  assign result     = (root_a == root_b) ? size_a : sum;

  assign rd_addr = (cmd.rd_op == RD_CUR) ? cur : node_sel;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur;
    wr_data = '0;
    unique case (cmd.wr_op)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_SWEEP: begin
        wr_addr = sweep_cnt;
      end
      WR_NEW: begin
        wr_addr = node_sel;
        wr_data = '{tag: epoch, parent: node_sel, size: SIZE_W'(1)};
      end
      WR_COMP: begin
        wr_addr = cur;
        wr_data = '{tag: rdata.tag, parent: root_sel, size: rdata.size};
      end
      WR_LOSER: begin
        wr_addr = loser;
        wr_data = '{tag: epoch, parent: winner, size: loser_size};
      end
      WR_WINNER: begin
        wr_addr = winner;
        wr_data = '{tag: epoch, parent: winner, size: sum};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_op != RD_NONE) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      node_a <= in_data[ID_W-1:0];
      node_b <= in_data[2*ID_W-1:ID_W];
    end
    case (cmd.cur_op)
      CUR_A:      cur <= node_a;
      CUR_B:      cur <= node_b;
      CUR_PARENT: cur <= rdata.parent;
      default:    cur <= cur;
    endcase
    if (cmd.root_load) begin
      if (cmd.side) begin
        root_b <= cur;
        size_b <= rdata.size;
      end else begin
        root_a <= cur;
        size_a <= rdata.size;
      end
    end
    if (cmd.out_load) begin
      m_tdata <= OUT_DATA_W'(result);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= TAG_W'(1);
      sweep_cnt <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.epoch_step) begin
        epoch <= status.epoch_last ? TAG_W'(1) : epoch + TAG_W'(1);
      end
      if (cmd.wr_op == WR_SWEEP) begin
        sweep_cnt <= sweep_cnt + ID_W'(1);
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign status.tag_match   = (rdata.tag == epoch);
  assign status.at_root     = (rdata.parent == cur);
  assign status.cur_is_root = (cur == root_sel);
  assign status.roots_equal = (root_a == root_b);
  assign status.epoch_last  = (epoch == {TAG_W{1'b1}});
  assign status.sweep_last  = (sweep_cnt == {ID_W{1'b1}});
  assign status.out_free    = !m_tvalid || m_tready;

  // tag 0 is reserved for swept entries
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    epoch != '0) else $error("epoch reached the swept tag");

  a_merge_order: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_op == WR_LOSER |-> loser > winner)
    else $error("merge keeps the larger root");

  a_comp_not_root: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_op == WR_COMP |-> cur != root_sel)
    else $error("compression rewrote a root");

endmodule

`default_nettype wire

@@ hdl/ufss_ctrl.sv @@
// ufss_ctrl: sequencer for sweep, seen check, root walk, path compression
// and merge. Depends on ufss_pkg.
`default_nettype none

module ufss_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  input  wire                  s_tuser,
  output logic                 s_tready,
  input  ufss_pkg::dp_status_t status,
  output ufss_pkg::dp_cmd_t    cmd
);
  import ufss_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        side;
  logic        side_next;
  logic        accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

  always_comb begin
    state_next     = state;
    side_next      = side;
    cmd.capture    = 1'b0;
    cmd.epoch_step = 1'b0;
    cmd.side       = side;
    cmd.rd_op      = RD_NONE;
    cmd.wr_op      = WR_NONE;
    cmd.cur_op     = CUR_HOLD;
    cmd.root_load  = 1'b0;
    cmd.out_load   = 1'b0;
    unique case (state)
      ST_SWEEP: begin
        cmd.wr_op = WR_SWEEP;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          side_next   = 1'b0;
          if (s_tuser) begin
            cmd.epoch_step = 1'b1;
            if (status.epoch_last) begin
              state_next = ST_SWEEP;
            end
          end else begin
            state_next = ST_SEEN_RD;
          end
        end
      end
      ST_SEEN_RD: begin
        cmd.rd_op  = RD_NODE;
        state_next = ST_SEEN_CHK;
      end
      ST_SEEN_CHK: begin
        if (!status.tag_match) begin
          cmd.wr_op = WR_NEW;
        end
        if (side) begin
          side_next  = 1'b0;
          cmd.cur_op = CUR_A;
          state_next = ST_WALK_RD;
        end else begin
          side_next  = 1'b1;
          state_next = ST_SEEN_RD;
        end
      end
      ST_WALK_RD: begin
        cmd.rd_op  = RD_CUR;
        state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (status.at_root) begin
          cmd.root_load = 1'b1;
          cmd.cur_op    = side ? CUR_B : CUR_A;
          state_next    = ST_COMP_RD;
        end else begin
          cmd.cur_op = CUR_PARENT;
          state_next = ST_WALK_RD;
        end
      end
      ST_COMP_RD: begin
        if (status.cur_is_root) begin
          if (side) begin
            side_next  = 1'b0;
            state_next = ST_MERGE;
          end else begin
            side_next  = 1'b1;
            cmd.cur_op = CUR_B;
            state_next = ST_WALK_RD;
          end
        end else begin
          cmd.rd_op  = RD_CUR;
          state_next = ST_COMP_WR;
        end
      end
      ST_COMP_WR: begin
        cmd.wr_op  = WR_COMP;
        cmd.cur_op = CUR_PARENT;
        state_next = ST_COMP_RD;
      end
      ST_MERGE: begin
        if (status.roots_equal) begin
          state_next = ST_OUT;
        end else begin
          cmd.wr_op  = WR_LOSER;
          state_next = ST_MERGE_WIN;
        end
      end
      ST_MERGE_WIN: begin
        cmd.wr_op  = WR_WINNER;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free) else $error("result overwrote a waiting beat");

  a_sweep_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && !status.sweep_last) |=> state == ST_SWEEP)
    else $error("sweep left early");

  a_join_start: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser) |=> (state == ST_SEEN_RD && !side))
    else $error("join did not start with node_a");

endmodule

`default_nettype wire

@@ hdl/union_find_set_size.sv @@
// union_find_set_size: top level, disjoint-set engine with set sizes.
// Depends on ufss_pkg, ufss_dp, ufss_ctrl.
//
//   channel | dir | tdata                             | tuser
//   s_*     | in  | [11:0] node_a, [23:12] node_b     | [0] cmd (1 = clear)
//   m_*     | out | [12:0] group_size, [15:13] zero   | -
//
// A join reads both node records, walks each node to its root and compresses
// the paths; every access goes through the single-port node record memory, one
// read or one write a cycle. A clear is taken in the idle state itself.
// After reset, and after every 255th clear, a sweep retags every memory
// entry; s_tready stays low meanwhile.
// A finished result waits in the output register; the next beat is taken
// while it waits.
`default_nettype none

module union_find_set_size (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [ufss_pkg::IN_DATA_W-1:0]    s_tdata,  // node_a, node_b
  input  wire                              s_tuser,  // cmd
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [ufss_pkg::OUT_DATA_W-1:0]  m_tdata   // group_size
);
  import ufss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ufss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ufss_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
